FILE: rtl/sgpc_pkg.sv
// sgpc_pkg: shared widths, register indexes, result types and helper functions
// for the scatter-gather page coalescer; depends on nothing
`default_nettype none

package sgpc_pkg;

	localparam int unsigned PAGE_BYTES = 4096;

	localparam int unsigned ADDR_W     = 48;
	localparam int unsigned OFF_W      = 32;
	localparam int unsigned LEN_W      = 32;
	localparam int unsigned TOT_W      = 48;
	localparam int unsigned CFG_DATA_W = 48;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BYTES  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SEGMENT  = CFG_IDX_W'(2);

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	localparam int unsigned RES_DEPTH = 4;
	localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
	localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

	localparam logic [LEN_W-1:0]  PAGE_LEN  = LEN_W'(PAGE_BYTES);
	localparam logic [LEN_W-1:0]  PAGE_MASK = ~(PAGE_LEN - LEN_W'(1));
	localparam logic [ADDR_W:0]   PAGE_END  = (ADDR_W + 1)'(PAGE_BYTES);

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [OFF_W-1:0]  offset;
		logic [LEN_W-1:0]  length;
		logic              final_seg;
		logic              status;
	} result_t;

	// up to two results per page; the second is only valid with the first
	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} push_t;

	// segment cap: zero is unlimited, round down to pages, never below one page
	function automatic logic [LEN_W-1:0] cap_of(input logic [LEN_W-1:0] m);
		logic [LEN_W-1:0] c;
		c = (m == '0) ? '1 : m;
		c = c & PAGE_MASK;
		if (c == '0)
			c = PAGE_LEN;
		return c;
	endfunction

	// bytes a closing segment describes, clamped to what is left
	function automatic logic [TOT_W-1:0] emit_len(input logic [OFF_W-1:0] off,
			input logic [LEN_W-1:0] rl, input logic [TOT_W-1:0] bl);
		logic [TOT_W-1:0] d;
		d = {{(TOT_W-LEN_W){1'b0}}, rl - off};
		if (off > rl)
			return bl;
		else if (d > bl)
			return bl;
		else
			return d;
	endfunction

	function automatic logic [LEN_W-1:0] sat_len(input logic [TOT_W-1:0] v);
		return (|v[TOT_W-1:LEN_W]) ? '1 : v[LEN_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/sgpc_result_fifo.sv
// sgpc_result_fifo: small result queue taking up to two results per cycle
// and giving one per cycle on a valid/ready port; depends on sgpc_pkg
`default_nettype none

module sgpc_result_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sgpc_pkg::push_t  push,
	output logic                  room2,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output sgpc_pkg::result_t     head
);
	import sgpc_pkg::*;

	result_t              mem [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q;
	logic [RES_PTR_W-1:0] rd_ptr_q;
	logic [RES_CNT_W-1:0] cnt_q;
	logic [RES_PTR_W-1:0] wr_ptr_p1;
	logic [RES_CNT_W-1:0] n_push;
	logic                 pop;

	assign wr_ptr_p1 = wr_ptr_q + RES_PTR_W'(1);
	assign n_push    = RES_CNT_W'(push.v0) + RES_CNT_W'(push.v1);
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign room2     = cnt_q <= RES_CNT_W'(RES_DEPTH - 2);
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.v0)
			mem[wr_ptr_q] <= push.r0;
		if (push.v1)
			mem[wr_ptr_p1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_PTR_W'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			cnt_q <= cnt_q + n_push - RES_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sgpc_core.sv
// sgpc_core: configuration registers, run state and the per-page merge and
// segment length logic; depends on sgpc_pkg
`default_nettype none

module sgpc_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write,
	input  wire logic [sgpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sgpc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             go,
	input  wire logic [sgpc_pkg::ADDR_W-1:0]      page_address,
	input  wire logic                             last_page,
	output sgpc_pkg::push_t                       push
);
	import sgpc_pkg::*;

	logic [OFF_W-1:0]  start_q;
	logic [TOT_W-1:0]  total_q;
	logic [LEN_W-1:0]  cap_q;
	logic [ADDR_W-1:0] run_base_q;
	logic [LEN_W-1:0]  run_len_q;
	logic [ADDR_W:0]   run_end_q;
	logic [TOT_W-1:0]  bytes_left_q;
	logic [OFF_W-1:0]  pending_q;
	logic              run_open_q;

	logic [ADDR_W-1:0] run_base_d;
	logic [LEN_W-1:0]  run_len_d;
	logic [ADDR_W:0]   run_end_d;
	logic [TOT_W-1:0]  bytes_left_d;
	logic [OFF_W-1:0]  pending_d;
	logic              run_open_d;

	logic              total_zero;
	logic              merge;
	logic              emit1;
	logic [TOT_W-1:0]  len1;
	logic [TOT_W-1:0]  len2;
	logic [TOT_W-1:0]  bl1;
	logic [OFF_W-1:0]  po1;
	logic [ADDR_W-1:0] rb_n;
	logic [LEN_W-1:0]  rl_n;
	logic [ADDR_W:0]   end_n;
	result_t           res_close;
	result_t           res_last;
	result_t           res_zero;

	// run end kept one bit wider than an address so a run reaching the top never merges
	always_comb begin
		total_zero = total_q == '0;
		merge = run_open_q && ({1'b0, page_address} == run_end_q) && (run_len_q < cap_q);
		emit1 = run_open_q && !merge;
		len1  = emit_len(pending_q, run_len_q, bytes_left_q);
		bl1   = emit1 ? bytes_left_q - len1 : bytes_left_q;
		po1   = emit1 ? '0 : pending_q;
		rb_n  = merge ? run_base_q : page_address;
		rl_n  = merge ? run_len_q + PAGE_LEN : PAGE_LEN;
		end_n = merge ? run_end_q + PAGE_END : {1'b0, page_address} + PAGE_END;
		len2  = emit_len(po1, rl_n, bl1);

		res_close.base      = run_base_q;
		res_close.offset    = pending_q;
		res_close.length    = sat_len(len1);
		res_close.final_seg = 1'b0;
		res_close.status    = STATUS_OK;

		res_last.base       = rb_n;
		res_last.offset     = po1;
		res_last.length     = sat_len(len2);
		res_last.final_seg  = 1'b1;
		res_last.status     = STATUS_OK;

		res_zero.base       = '0;
		res_zero.offset     = '0;
		res_zero.length     = '0;
		res_zero.final_seg  = 1'b1;
		res_zero.status     = STATUS_INVALID;

		push.v0 = 1'b0;
		push.v1 = 1'b0;
		push.r0 = res_last;
		push.r1 = res_last;

		run_base_d   = run_base_q;
		run_len_d    = run_len_q;
		run_end_d    = run_end_q;
		bytes_left_d = bytes_left_q;
		pending_d    = pending_q;
		run_open_d   = run_open_q;

		if (total_zero) begin
			push.v0 = go && last_page;
			push.r0 = res_zero;
		end else begin
			if (emit1) begin
				push.v0 = go;
				push.r0 = res_close;
				push.v1 = go && last_page;
			end else begin
				push.v0 = go && last_page;
			end
			run_base_d   = rb_n;
			run_len_d    = rl_n;
			run_end_d    = end_n;
			bytes_left_d = bl1;
			pending_d    = po1;
			run_open_d   = 1'b1;
		end

		// end of list: drop the run and reload the counters for the next list
		if (last_page) begin
			run_base_d   = '0;
			run_len_d    = '0;
			run_end_d    = '0;
			bytes_left_d = total_q;
			pending_d    = start_q;
			run_open_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q      <= '0;
			total_q      <= '0;
			cap_q        <= cap_of('0);
			run_base_q   <= '0;
			run_len_q    <= '0;
			run_end_q    <= '0;
			bytes_left_q <= '0;
			pending_q    <= '0;
			run_open_q   <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_START_OFFSET: begin
					start_q   <= cfg_data[OFF_W-1:0];
					pending_q <= cfg_data[OFF_W-1:0];
				end
				REG_TOTAL_BYTES: begin
					total_q      <= cfg_data[TOT_W-1:0];
					bytes_left_q <= cfg_data[TOT_W-1:0];
				end
				REG_MAX_SEGMENT: begin
					cap_q <= cap_of(cfg_data[LEN_W-1:0]);
				end
				default: begin
				end
			endcase
		end else if (go) begin
			run_base_q   <= run_base_d;
			run_len_q    <= run_len_d;
			run_end_q    <= run_end_d;
			bytes_left_q <= bytes_left_d;
			pending_q    <= pending_d;
			run_open_q   <= run_open_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sg_page_coalescer_unit.sv
// sg_page_coalescer_unit: top level of the scatter-gather page coalescer
// depends on sgpc_pkg, sgpc_core and sgpc_result_fifo
//
// usage: program start_offset, total_bytes and max_segment_bytes through the
// write port (cfg_write, cfg_index, cfg_data) while the block is idle, then
// stream page addresses on in_valid/in_ready, last_page set on the final one.
// segments come out on out_valid/out_ready, one item per accepted handshake.
// order: an accepted page is merged once it sits in the input register
// with room in the queue, and its results are offered from the cycle after.
// throughput: one page per cycle while the queue has room for two results.
// a page may close a segment and, as last page, also give the final one, so
// two results can be queued at once; the four-entry result queue drains one
// item per cycle while out_ready is high and stalls the input register when
// fewer than two slots are free, so a stalled receiver backs up into in_ready.
// reset clears the registers to zero (unlimited segment cap), empties the
// queue and closes any open run.
`default_nettype none

module sg_page_coalescer_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write,
	input  wire logic [sgpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sgpc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [sgpc_pkg::ADDR_W-1:0]      page_address,
	input  wire logic                             last_page,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [sgpc_pkg::ADDR_W-1:0]           segment_base,
	output logic [sgpc_pkg::OFF_W-1:0]            segment_offset,
	output logic [sgpc_pkg::LEN_W-1:0]            segment_length,
	output logic                                  final_segment,
	output logic                                  status
);
	import sgpc_pkg::*;

	logic              s1_valid_q;
	logic [ADDR_W-1:0] pa_s1;
	logic              last_s1;
	logic              room2;
	logic              go;
	push_t             push;
	result_t           head;

	assign go       = s1_valid_q && room2;
	assign in_ready = !s1_valid_q || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pa_s1   <= page_address;
			last_s1 <= last_page;
		end
	end

	sgpc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.go           (go),
		.page_address (pa_s1),
		.last_page    (last_s1),
		.push         (push)
	);

	sgpc_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign segment_base   = head.base;
	assign segment_offset = head.offset;
	assign segment_length = head.length;
	assign final_segment  = head.final_seg;
	assign status         = head.status;

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0)
		else $error("second result pushed without a first");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> last_s1)
		else $error("two results from a page that is not the last");

	a_held_page: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !go |=> s1_valid_q && $stable(pa_s1) && $stable(last_s1))
		else $error("stalled page lost or changed in the input register");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		push.v0 |=> out_valid)
		else $error("queued result not offered");

endmodule

`default_nettype wire

FILE: dv/sgpc_checker.sv
// sgpc_checker: watches the register port and both item channels of the page
// coalescer, predicts every segment item and compares it field by field
// depends on sgpc_pkg for widths, register indexes and the result struct
module sgpc_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [sgpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sgpc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	input  wire logic                            in_ready,
	input  wire logic [sgpc_pkg::ADDR_W-1:0]     page_address,
	input  wire logic                            last_page,
	input  wire logic                            out_valid,
	input  wire logic                            out_ready,
	input  wire logic [sgpc_pkg::ADDR_W-1:0]     segment_base,
	input  wire logic [sgpc_pkg::OFF_W-1:0]      segment_offset,
	input  wire logic [sgpc_pkg::LEN_W-1:0]      segment_length,
	input  wire logic                            final_segment,
	input  wire logic                            status,
	output int                                   mismatches,
	output int                                   outstanding,
	output int                                   segments_seen
);
	import sgpc_pkg::*;

	// programmed registers
	logic [OFF_W-1:0]  cfg_start;
	logic [TOT_W-1:0]  cfg_total;
	logic [LEN_W-1:0]  cfg_max;

	// predicted coalescing state
	logic [ADDR_W-1:0] open_base;
	logic [LEN_W-1:0]  open_len;
	logic [TOT_W-1:0]  remaining;
	logic [OFF_W-1:0]  first_offset;
	logic              run_active;

	result_t segment_q[$];

	// cap in bytes: zero is unlimited, whole pages only, at least one page
	function automatic logic [63:0] segment_cap();
		logic [63:0] c;
		c = (cfg_max == '0) ? 64'hFFFF_FFFF : {32'b0, cfg_max};
		c = c & ~(64'(PAGE_BYTES) - 64'd1) & 64'hFFFF_FFFF;
		if (c == 64'd0)
			c = 64'(PAGE_BYTES);
		return c;
	endfunction

	task automatic restart_list();
		run_active   = 1'b0;
		open_base    = '0;
		open_len     = '0;
		remaining    = cfg_total;
		first_offset = cfg_start;
	endtask

	task automatic close_run(input logic fin);
		logic [63:0] len;
		result_t r;
		// an offset past the run end takes everything that is left
		if (first_offset > open_len)
			len = {16'b0, remaining};
		else
			len = {32'b0, open_len - first_offset};
		if (len > {16'b0, remaining})
			len = {16'b0, remaining};
		remaining = remaining - len[TOT_W-1:0];
		r.base      = open_base;
		r.offset    = first_offset;
		r.length    = (len > 64'hFFFF_FFFF) ? '1 : len[LEN_W-1:0];
		r.final_seg = fin;
		r.status    = STATUS_OK;
		first_offset = '0;
		segment_q.push_back(r);
	endtask

	task automatic take_page(input logic [ADDR_W-1:0] addr, input logic last);
		logic [63:0] run_end;
		logic [63:0] cap;
		result_t r;
		cap = segment_cap();
		if (cfg_total == '0) begin
			// nothing to describe: pages are dropped, the last one reports invalid
			if (last) begin
				r = '0;
				r.final_seg = 1'b1;
				r.status    = STATUS_INVALID;
				segment_q.push_back(r);
				restart_list();
			end
		end else begin
			// no wrap: a run ending at the top of the space never merges
			run_end = {16'b0, open_base} + {32'b0, open_len};
			if (run_active && {16'b0, addr} == run_end && {32'b0, open_len} < cap) begin
				open_len = open_len + PAGE_LEN;
			end else begin
				if (run_active)
					close_run(1'b0);
				open_base  = addr;
				open_len   = PAGE_LEN;
				run_active = 1'b1;
			end
			if (last) begin
				close_run(1'b1);
				restart_list();
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		logic bad;
		if (!arst_n) begin
			cfg_start     = '0;
			cfg_total     = '0;
			cfg_max       = '0;
			restart_list();
			segment_q.delete();
			mismatches    = 0;
			outstanding   = 0;
			segments_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				segments_seen++;
				if (segment_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected segment item: base %h offset %h length %h",
							segment_base, segment_offset, segment_length);
					mismatches++;
				end else begin
					want = segment_q.pop_front();
					bad = (segment_base !== want.base) || (segment_offset !== want.offset) ||
						(segment_length !== want.length) ||
						(final_segment !== want.final_seg) || (status !== want.status);
					if (bad) begin
						if (mismatches < 10) begin
							$display("segment mismatch, expected / actual:");
							$display("  base %h / %h  offset %h / %h  length %h / %h",
								want.base, segment_base, want.offset, segment_offset,
								want.length, segment_length);
							$display("  final %b / %b  status %b / %b",
								want.final_seg, final_segment, want.status, status);
						end
						mismatches++;
					end
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_START_OFFSET: begin
						cfg_start    = cfg_data[OFF_W-1:0];
						first_offset = cfg_start;
					end
					REG_TOTAL_BYTES: begin
						cfg_total = cfg_data[TOT_W-1:0];
						remaining = cfg_total;
					end
					REG_MAX_SEGMENT: begin
						cfg_max = cfg_data[LEN_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready)
				take_page(page_address, last_page);
			outstanding = segment_q.size();
		end
	end

endmodule

FILE: dv/testbench.sv
// testbench: drives register settings and page lists into the page coalescer
// with random idling on both channels and gives the verdict
// depends on sgpc_pkg, sg_page_coalescer_unit and sgpc_checker
module testbench;
	import sgpc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(3);
	localparam int RANDOM_PAGES = 1350;
	localparam int SETTLE       = 8;
	localparam int CYCLE_LIMIT  = 1_000_000;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  cfg_write    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic [ADDR_W-1:0]     page_address = '0;
	logic                  last_page    = 1'b0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic [ADDR_W-1:0]     segment_base;
	logic [OFF_W-1:0]      segment_offset;
	logic [LEN_W-1:0]      segment_length;
	logic                  final_segment;
	logic                  status;

	int mismatches;
	int outstanding;
	int segments_seen;

	bit feed_idle = 1'b1;
	bit sink_idle = 1'b1;
	logic [TOT_W-1:0] cur_total = '0;
	int pages_counted = 0;
	int settings = 0;

	logic [CFG_IDX_W-1:0] reg_ids [4] = '{REG_START_OFFSET, REG_TOTAL_BYTES,
		REG_MAX_SEGMENT, REG_NONE};

	sg_page_coalescer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.page_address(page_address), .last_page(last_page),
		.out_valid(out_valid), .out_ready(out_ready),
		.segment_base(segment_base), .segment_offset(segment_offset),
		.segment_length(segment_length), .final_segment(final_segment),
		.status(status)
	);

	sgpc_checker watch (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.page_address(page_address), .last_page(last_page),
		.out_valid(out_valid), .out_ready(out_ready),
		.segment_base(segment_base), .segment_offset(segment_offset),
		.segment_length(segment_length), .final_segment(final_segment),
		.status(status),
		.mismatches(mismatches), .outstanding(outstanding),
		.segments_seen(segments_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int idle_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 70)
			return 0;
		else if (k < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	function automatic logic [ADDR_W-1:0] rand48();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		return v[ADDR_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] random_page();
		logic [ADDR_W-1:0] a;
		a = rand48();
		// now and then start close to the top so runs reach the end of the space
		if ($urandom_range(0, 19) == 0)
			a = '1 - ADDR_W'($urandom_range(0, 6)) * ADDR_W'(PAGE_BYTES);
		return a & ~ADDR_W'(PAGE_BYTES - 1);
	endfunction

	function automatic logic [OFF_W-1:0] pick_offset();
		int k;
		k = $urandom_range(0, 9);
		if (k < 4)
			return '0;
		else if (k < 7)
			return OFF_W'($urandom_range(0, 2 * PAGE_BYTES));
		else if (k < 8)
			return OFF_W'($urandom_range(0, 12 * PAGE_BYTES));
		else if (k < 9)
			return $urandom();
		else
			return '1;
	endfunction

	function automatic logic [TOT_W-1:0] pick_total();
		int k;
		k = $urandom_range(0, 19);
		if (k == 0)
			return '0;
		else if (k == 1)
			return '1;
		else if (k < 4)
			return rand48();
		else if (k < 8)
			return TOT_W'($urandom_range(1, PAGE_BYTES));
		else
			return TOT_W'($urandom_range(1, 16 * PAGE_BYTES));
	endfunction

	function automatic logic [LEN_W-1:0] pick_cap();
		int k;
		k = $urandom_range(0, 9);
		if (k < 3)
			return '0;
		else if (k < 4)
			return LEN_W'($urandom_range(0, PAGE_BYTES - 1));
		else if (k < 7)
			return LEN_W'(PAGE_BYTES * $urandom_range(1, 4) + $urandom_range(0, PAGE_BYTES - 1));
		else if (k < 8)
			return $urandom();
		else if (k < 9)
			return '1;
		else
			return PAGE_MASK;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_TOTAL_BYTES)
			cur_total = val;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// upper data bits are junk for the 32-bit registers
	task automatic write_random_reg(input logic [CFG_IDX_W-1:0] idx);
		logic [CFG_DATA_W-1:0] val;
		case (idx)
			REG_START_OFFSET: val = {16'($urandom()), pick_offset()};
			REG_TOTAL_BYTES:  val = pick_total();
			REG_MAX_SEGMENT:  val = {16'($urandom()), pick_cap()};
			default:          val = rand48();
		endcase
		write_reg(idx, val);
	endtask

	task automatic send_page(input logic [ADDR_W-1:0] addr, input logic last);
		int gap;
		in_valid     <= 1'b1;
		page_address <= addr;
		last_page    <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// pages dropped under a zero total do not count
		if (cur_total != '0 || last)
			pages_counted++;
		gap = feed_idle ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold the sender until every predicted item is back, then let the block settle
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_list(input int n);
		logic [ADDR_W-1:0] addr;
		int k;
		addr = random_page();
		for (int i = 0; i < n; i++) begin
			if (i > 0) begin
				k = $urandom_range(0, 19);
				if (k < 14)
					addr = addr + ADDR_W'(PAGE_BYTES);
				else if (k < 18)
					addr = random_page();
				else if (k < 19)
					addr = addr - ADDR_W'(PAGE_BYTES);
				else
					addr = rand48();
			end
			send_page(addr, i == n - 1);
			// pause with a run open, sometimes retune a register there
			if (i < n - 1 && $urandom_range(0, 39) == 0) begin
				settle();
				if ($urandom_range(0, 1) == 1)
					write_random_reg(reg_ids[$urandom_range(0, 3)]);
			end
		end
	endtask

	initial begin : sink
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				hold = sink_idle ? idle_len() : 0;
				out_ready <= (hold == 0);
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("FAIL sg_page_coalescer_unit");
		$finish;
	end

	initial begin : stimulus
		int goal;
		int k;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// contiguous run, a jump, start offset in the first page, unlimited cap
		write_reg(REG_START_OFFSET, 48'd100);
		write_reg(REG_TOTAL_BYTES, 48'(5 * PAGE_BYTES));
		write_reg(REG_MAX_SEGMENT, 48'd0);
		send_page(48'h0000_0010_0000, 1'b0);
		send_page(48'h0000_0010_1000, 1'b0);
		send_page(48'h0000_0010_2000, 1'b0);
		send_page(48'h0000_0800_0000, 1'b0);
		send_page(48'h0000_0800_1000, 1'b1);
		settle();

		// top of the address space, offset past the first segment, saturated length
		write_reg(REG_START_OFFSET, 48'hFFFF_FFFF_FFFF);
		write_reg(REG_TOTAL_BYTES, 48'hFFFF_FFFF_FFFF);
		send_page(48'hFFFF_FFFF_E000, 1'b0);
		send_page(48'hFFFF_FFFF_F000, 1'b0);
		send_page(48'h0000_0000_0000, 1'b1);
		settle();

		// cap below one page, unaligned address, clamping down to zero length
		write_reg(REG_MAX_SEGMENT, 48'd100);
		write_reg(REG_START_OFFSET, 48'd0);
		write_reg(REG_TOTAL_BYTES, 48'(3 * PAGE_BYTES - 5));
		send_page(48'h1234_5678_9ABC, 1'b0);
		send_page(48'h1234_5678_AABC, 1'b0);
		send_page(48'h1234_5678_BABC, 1'b0);
		send_page(48'h1234_5678_CABC, 1'b1);
		settle();

		// zero total: dropped pages, then an invalid final item
		write_reg(REG_TOTAL_BYTES, 48'd0);
		write_reg(REG_NONE, rand48());
		send_page(48'h0000_0000_3000, 1'b0);
		send_page(48'h0000_0000_4000, 1'b0);
		send_page(48'h0000_0000_5000, 1'b1);
		settle();

		// registers rewritten while a run is open
		write_reg(REG_MAX_SEGMENT, 48'd8192);
		write_reg(REG_START_OFFSET, 48'd50);
		write_reg(REG_TOTAL_BYTES, 48'd10000);
		send_page(48'h0000_4000_0000, 1'b0);
		send_page(48'h0000_4000_1000, 1'b0);
		settle();
		write_reg(REG_TOTAL_BYTES, 48'd3000);
		write_reg(REG_START_OFFSET, 48'd7);
		send_page(48'h0000_4000_2000, 1'b0);
		send_page(48'h0000_4000_3000, 1'b1);
		settle();

		// largest cap
		write_reg(REG_MAX_SEGMENT, 48'hFFFF_FFFF_FFFF);
		write_reg(REG_START_OFFSET, 48'd0);
		write_reg(REG_TOTAL_BYTES, 48'hFFFF_FFFF_FFFF);
		send_page(48'h7FFF_FFFF_F000, 1'b0);
		send_page(48'h8000_0000_0000, 1'b0);
		send_page(48'h8000_0000_1000, 1'b1);
		settle();
		settings = 6;

		goal = pages_counted + RANDOM_PAGES;
		while (pages_counted < goal) begin
			settle();
			settings++;
			feed_idle = ($urandom_range(0, 4) != 0);
			sink_idle = ($urandom_range(0, 4) != 0);
			for (int r = 0; r < 3; r++)
				if ($urandom_range(0, 2) != 0)
					write_random_reg(reg_ids[r]);
			if ($urandom_range(0, 9) == 0)
				write_random_reg(REG_NONE);
			k = $urandom_range(1, 5);
			for (int l = 0; l < k; l++) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: arbitrary addresses and last flags
					for (int p = $urandom_range(1, 4); p > 0; p--)
						send_page(rand48(), 1'($urandom_range(0, 1)));
				end else if ($urandom_range(0, 14) == 0) begin
					send_list($urandom_range(12, 30));
				end else begin
					send_list($urandom_range(1, 10));
				end
			end
		end
		settle();

		$display("ran %0d counted pages over %0d register settings", pages_counted, settings);
		$display("checked %0d segment items, %0d mismatches", segments_seen, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS sg_page_coalescer_unit");
		else
			$display("FAIL sg_page_coalescer_unit");
		$finish;
	end

endmodule

FILE: files.f
rtl/sgpc_pkg.sv
rtl/sgpc_result_fifo.sv
rtl/sgpc_core.sv
rtl/sg_page_coalescer_unit.sv
dv/sgpc_checker.sv
dv/testbench.sv
